// ----- sv/sfc_pkg.sv -----
// Package for the sphere frustum cull and level-of-detail block.
// Holds shared widths, register indexes and the structs passed along the cell chains.
// No dependencies.
package sfc_pkg;

	localparam int COORD_W = 24;
	localparam int ENTRY_W = 16;
	localparam int NORM_W = 17;
	localparam int DOT_W = 44;
	localparam int LEN2_W = 36;
	localparam int SQ_W = 88;
	localparam int DIST2_W = 52;
	localparam int ROOT_W = 26;
	localparam int ROOT_STAGES = 26;
	localparam int DIST_W = 24;
	localparam int LOD_W = 3;
	localparam int THR_W = 16;
	localparam int NUM_PLANES = 6;
	localparam int COORD_FRAC_BITS_DEF = 8;
	localparam int ADDR_W = 6;
	localparam int DATA_W = 64;

	localparam logic [2:0] REG_COL0 = 3'd0;
	localparam logic [2:0] REG_COL1 = 3'd1;
	localparam logic [2:0] REG_COL2 = 3'd2;
	localparam logic [2:0] REG_COL3 = 3'd3;
	localparam logic [2:0] REG_CAMX = 3'd4;
	localparam logic [2:0] REG_CAMY = 3'd5;
	localparam logic [2:0] REG_CAMZ = 3'd6;
	localparam logic [2:0] REG_LOD = 3'd7;

	localparam logic [LOD_W-1:0] LOD_FAR = 3'd4;

	typedef struct packed {
		logic signed [NORM_W-1:0] nx;
		logic signed [NORM_W-1:0] ny;
		logic signed [NORM_W-1:0] nz;
		logic signed [NORM_W-1:0] d;
	} plane_t;

	// State carried from one square-root cell to the next.
	typedef struct packed {
		logic [DIST2_W-1:0] rem;
		logic [ROOT_W-1:0] root;
	} root_t;

endpackage

// ----- sv/sfc_regs.sv -----
// Configuration register file with APB-style write and read access.
// Derives the six frustum planes from the stored matrix columns. Uses sfc_pkg.
module sfc_regs (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [sfc_pkg::ADDR_W-1:0] paddr,
	input  logic [sfc_pkg::DATA_W-1:0] pwdata,
	output logic [sfc_pkg::DATA_W-1:0] prdata,
	output sfc_pkg::plane_t planes [sfc_pkg::NUM_PLANES],
	output logic signed [sfc_pkg::COORD_W-1:0] cam_x,
	output logic signed [sfc_pkg::COORD_W-1:0] cam_y,
	output logic signed [sfc_pkg::COORD_W-1:0] cam_z,
	output logic [4*sfc_pkg::THR_W-1:0] thr
);

	logic [63:0] col_q [4];
	logic [sfc_pkg::COORD_W-1:0] camx_q, camy_q, camz_q;
	logic [63:0] lod_q;
	logic [2:0] idx;
	logic wr;

	assign idx = paddr[5:3];
	assign wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q[0] <= 64'h0000_0000_0000_0100;
			col_q[1] <= 64'h0000_0000_0100_0000;
			col_q[2] <= 64'h0000_0100_0000_0000;
			col_q[3] <= 64'h0100_0000_0000_0000;
			camx_q <= '0;
			camy_q <= '0;
			camz_q <= '0;
			lod_q <= '0;
		end else if (wr) begin
			case (idx)
				sfc_pkg::REG_COL0: col_q[0] <= pwdata;
				sfc_pkg::REG_COL1: col_q[1] <= pwdata;
				sfc_pkg::REG_COL2: col_q[2] <= pwdata;
				sfc_pkg::REG_COL3: col_q[3] <= pwdata;
				sfc_pkg::REG_CAMX: camx_q <= pwdata[sfc_pkg::COORD_W-1:0];
				sfc_pkg::REG_CAMY: camy_q <= pwdata[sfc_pkg::COORD_W-1:0];
				sfc_pkg::REG_CAMZ: camz_q <= pwdata[sfc_pkg::COORD_W-1:0];
				sfc_pkg::REG_LOD: lod_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			sfc_pkg::REG_COL0: prdata = col_q[0];
			sfc_pkg::REG_COL1: prdata = col_q[1];
			sfc_pkg::REG_COL2: prdata = col_q[2];
			sfc_pkg::REG_COL3: prdata = col_q[3];
			sfc_pkg::REG_CAMX: prdata = {40'd0, camx_q};
			sfc_pkg::REG_CAMY: prdata = {40'd0, camy_q};
			sfc_pkg::REG_CAMZ: prdata = {40'd0, camz_q};
			sfc_pkg::REG_LOD: prdata = lod_q;
			default: prdata = '0;
		endcase
	end

	function automatic logic signed [sfc_pkg::NORM_W-1:0] ent(input logic [63:0] c,
			input int r);
		logic [15:0] e;
		e = c[16*r +: 16];
		return {e[15], e};
	endfunction

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			planes[2*k].nx = ent(col_q[0], 3) + ent(col_q[0], k);
			planes[2*k].ny = ent(col_q[1], 3) + ent(col_q[1], k);
			planes[2*k].nz = ent(col_q[2], 3) + ent(col_q[2], k);
			planes[2*k].d = ent(col_q[3], 3) + ent(col_q[3], k);
			planes[2*k+1].nx = ent(col_q[0], 3) - ent(col_q[0], k);
			planes[2*k+1].ny = ent(col_q[1], 3) - ent(col_q[1], k);
			planes[2*k+1].nz = ent(col_q[2], 3) - ent(col_q[2], k);
			planes[2*k+1].d = ent(col_q[3], 3) - ent(col_q[3], k);
		end
	end

	assign cam_x = camx_q;
	assign cam_y = camy_q;
	assign cam_z = camz_q;
	assign thr = lod_q;

endmodule

// ----- sv/sfc_plane_cell.sv -----
// One plane-test cell: six registered steps on a single frustum plane.
// Hands the running visibility flag on to the next cell. Uses sfc_pkg.
module sfc_plane_cell #(
	parameter int COORD_FRAC_BITS = sfc_pkg::COORD_FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic en,
	input  sfc_pkg::plane_t plane,
	input  logic signed [sfc_pkg::COORD_W-1:0] px,
	input  logic signed [sfc_pkg::COORD_W-1:0] py,
	input  logic signed [sfc_pkg::COORD_W-1:0] pz,
	input  logic [sfc_pkg::COORD_W-1:0] r,
	input  logic vis_in,
	output logic vis_out
);

	localparam int MH = sfc_pkg::DOT_W / 2;
	localparam int RH = sfc_pkg::COORD_W;
	localparam int LH = sfc_pkg::LEN2_W / 2;

	logic signed [sfc_pkg::DOT_W-1:0] mx_s1, my_s1, mz_s1, md_s1;
	logic [sfc_pkg::LEN2_W-1:0] lx_s1, ly_s1, lz_s1;
	logic [47:0] rr_s1;
	logic vis_s1;
	logic signed [sfc_pkg::DOT_W-1:0] s_s2;
	logic [sfc_pkg::LEN2_W-1:0] len2_s2;
	logic [47:0] rr_s2;
	logic vis_s2;
	logic [sfc_pkg::DOT_W-1:0] mag_s3;
	logic [sfc_pkg::LEN2_W-1:0] len2_s3;
	logic [47:0] rr_s3;
	logic neg_s3, deg_s3, vis_s3;
	logic [2*MH-1:0] mhh_s4, mhl_s4, mll_s4;
	logic [RH+LH-1:0] phh_s4, phl_s4, plh_s4, pll_s4;
	logic neg_s4, deg_s4, vis_s4;
	logic [sfc_pkg::SQ_W-1:0] lhs_s5, rhs_s5;
	logic neg_s5, deg_s5, vis_s5;
	logic vis_q;

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s1 <= sfc_pkg::DOT_W'(plane.nx * px);
			my_s1 <= sfc_pkg::DOT_W'(plane.ny * py);
			mz_s1 <= sfc_pkg::DOT_W'(plane.nz * pz);
			md_s1 <= sfc_pkg::DOT_W'(plane.d) <<< COORD_FRAC_BITS;
			lx_s1 <= sfc_pkg::LEN2_W'(plane.nx * plane.nx);
			ly_s1 <= sfc_pkg::LEN2_W'(plane.ny * plane.ny);
			lz_s1 <= sfc_pkg::LEN2_W'(plane.nz * plane.nz);
			rr_s1 <= r * r;
			vis_s1 <= vis_in;

			s_s2 <= mx_s1 + my_s1 + mz_s1 + md_s1;
			len2_s2 <= lx_s1 + ly_s1 + lz_s1;
			rr_s2 <= rr_s1;
			vis_s2 <= vis_s1;

			neg_s3 <= s_s2[sfc_pkg::DOT_W-1];
			mag_s3 <= sfc_pkg::DOT_W'(-s_s2);
			deg_s3 <= (len2_s2 == '0);
			len2_s3 <= len2_s2;
			rr_s3 <= rr_s2;
			vis_s3 <= vis_s2;

			mhh_s4 <= mag_s3[2*MH-1:MH] * mag_s3[2*MH-1:MH];
			mhl_s4 <= mag_s3[2*MH-1:MH] * mag_s3[MH-1:0];
			mll_s4 <= mag_s3[MH-1:0] * mag_s3[MH-1:0];
			phh_s4 <= rr_s3[2*RH-1:RH] * len2_s3[2*LH-1:LH];
			phl_s4 <= rr_s3[2*RH-1:RH] * len2_s3[LH-1:0];
			plh_s4 <= rr_s3[RH-1:0] * len2_s3[2*LH-1:LH];
			pll_s4 <= rr_s3[RH-1:0] * len2_s3[LH-1:0];
			neg_s4 <= neg_s3;
			deg_s4 <= deg_s3;
			vis_s4 <= vis_s3;

			lhs_s5 <= (sfc_pkg::SQ_W'(mhh_s4) << (2*MH)) + (sfc_pkg::SQ_W'(mhl_s4) << (MH+1))
				+ sfc_pkg::SQ_W'(mll_s4);
			rhs_s5 <= (sfc_pkg::SQ_W'(phh_s4) << (RH+LH)) + (sfc_pkg::SQ_W'(phl_s4) << RH)
				+ (sfc_pkg::SQ_W'(plh_s4) << LH) + sfc_pkg::SQ_W'(pll_s4);
			neg_s5 <= neg_s4;
			deg_s5 <= deg_s4;
			vis_s5 <= vis_s4;

			vis_q <= vis_s5 && !(neg_s5 && !deg_s5 && (lhs_s5 > rhs_s5));
		end
	end

	assign vis_out = vis_q;

endmodule

// ----- sv/sfc_root_cell.sv -----
// One square-root cell: settles a single result bit of the integer root.
// Passes the remainder and partial root to the next cell. Uses sfc_pkg.
module sfc_root_cell #(
	parameter int STEP = 0
) (
	input  logic clk,
	input  logic en,
	input  sfc_pkg::root_t in_q,
	output sfc_pkg::root_t out_q
);

	localparam int SH = 2 * (sfc_pkg::ROOT_STAGES - 1 - STEP);

	logic [sfc_pkg::DIST2_W+1:0] trial;
	logic [sfc_pkg::DIST2_W+1:0] cand;
	sfc_pkg::root_t nxt;

	always_comb begin
		cand = (sfc_pkg::DIST2_W+2)'({in_q.root, 2'b01}) << SH;
		trial = {2'b00, in_q.rem};
		nxt = in_q;
		if (trial >= cand) begin
			nxt.rem = sfc_pkg::DIST2_W'(trial - cand);
			nxt.root = {in_q.root[sfc_pkg::ROOT_W-2:0], 1'b1};
		end else begin
			nxt.root = {in_q.root[sfc_pkg::ROOT_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (en) out_q <= nxt;
	end

endmodule

// ----- sv/sphere_frustum_cull_lod.sv -----
// Top level of the sphere frustum cull and level-of-detail block.
// Uses sfc_pkg, sfc_regs, sfc_plane_cell and sfc_root_cell.
//
//  channel | valid    | stall     | payload
//  input   | in_valid | in_stall  | center_x center_y center_z radius
//  output  | out_valid| out_stall | visible lod_level camera_distance
//  config  | psel/penable/pwrite, pready high | paddr pwdata prdata
//
// One sphere a cycle unless the output stalls. A result passes the input beat register,
// six plane cells of six steps each, then the output register. The distance path
// taps the coordinate line so its three squaring steps and 26 root cells end level.
// The whole pipeline holds while the output register is full and stalled.
// Reset clears all valid flags; registers return to the identity matrix.
module sphere_frustum_cull_lod #(
	parameter int COORD_FRAC_BITS = sfc_pkg::COORD_FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [sfc_pkg::ADDR_W-1:0] paddr,
	input  logic [sfc_pkg::DATA_W-1:0] pwdata,
	output logic [sfc_pkg::DATA_W-1:0] prdata,
	output logic pready,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [sfc_pkg::COORD_W-1:0] center_x,
	input  logic signed [sfc_pkg::COORD_W-1:0] center_y,
	input  logic signed [sfc_pkg::COORD_W-1:0] center_z,
	input  logic [sfc_pkg::COORD_W-1:0] radius,
	output logic out_valid,
	input  logic out_stall,
	output logic visible,
	output logic [sfc_pkg::LOD_W-1:0] lod_level,
	output logic [sfc_pkg::DIST_W-1:0] camera_distance
);

	localparam int PLANE_LAT = 6;
	localparam int CHAIN_LAT = PLANE_LAT * sfc_pkg::NUM_PLANES;
	localparam int TAP_LEN = (sfc_pkg::NUM_PLANES - 1) * PLANE_LAT + 1;
	localparam int DTAP = CHAIN_LAT - 3 - sfc_pkg::ROOT_STAGES;

	sfc_pkg::plane_t planes [sfc_pkg::NUM_PLANES];
	logic signed [sfc_pkg::COORD_W-1:0] cam_x, cam_y, cam_z;
	logic [4*sfc_pkg::THR_W-1:0] thr;
	logic adv;
	logic [CHAIN_LAT:0] v_q;

	// Pipeline advances only as a whole, so the chain is a clock-enabled delay.
	assign adv = !out_valid || !out_stall;
	assign in_stall = !adv;
	assign pready = 1'b1;

	sfc_regs u_regs (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .planes(planes),
		.cam_x(cam_x), .cam_y(cam_y), .cam_z(cam_z), .thr(thr)
	);

	// Input beat registers and coordinate delay line aligned to each plane cell.
	logic signed [sfc_pkg::COORD_W-1:0] px_q [TAP_LEN];
	logic signed [sfc_pkg::COORD_W-1:0] py_q [TAP_LEN];
	logic signed [sfc_pkg::COORD_W-1:0] pz_q [TAP_LEN];
	logic [sfc_pkg::COORD_W-1:0] r_q [TAP_LEN];
	logic vis_c [sfc_pkg::NUM_PLANES+1];

	always_ff @(posedge clk) begin
		if (adv) begin
			px_q[0] <= center_x;
			py_q[0] <= center_y;
			pz_q[0] <= center_z;
			r_q[0] <= radius;
			for (int i = 1; i < TAP_LEN; i++) begin
				px_q[i] <= px_q[i-1];
				py_q[i] <= py_q[i-1];
				pz_q[i] <= pz_q[i-1];
				r_q[i] <= r_q[i-1];
			end
		end
	end

	assign vis_c[0] = 1'b1;

	genvar g;
	generate
		for (g = 0; g < sfc_pkg::NUM_PLANES; g++) begin : g_plane
			sfc_plane_cell #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_cell (
				.clk(clk), .en(adv), .plane(planes[g]), .px(px_q[g*PLANE_LAT]),
				.py(py_q[g*PLANE_LAT]), .pz(pz_q[g*PLANE_LAT]), .r(r_q[g*PLANE_LAT]),
				.vis_in(vis_c[g]), .vis_out(vis_c[g+1])
			);
		end
	endgenerate

	// Distance squared, then the root chain.
	logic signed [sfc_pkg::COORD_W:0] dx_s1, dy_s1, dz_s1;
	logic [sfc_pkg::DIST2_W-1:0] qx_s2, qy_s2, qz_s2;
	logic [sfc_pkg::DIST2_W-1:0] sum_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1 <= {px_q[DTAP][sfc_pkg::COORD_W-1], px_q[DTAP]}
				- {cam_x[sfc_pkg::COORD_W-1], cam_x};
			dy_s1 <= {py_q[DTAP][sfc_pkg::COORD_W-1], py_q[DTAP]}
				- {cam_y[sfc_pkg::COORD_W-1], cam_y};
			dz_s1 <= {pz_q[DTAP][sfc_pkg::COORD_W-1], pz_q[DTAP]}
				- {cam_z[sfc_pkg::COORD_W-1], cam_z};
			qx_s2 <= sfc_pkg::DIST2_W'(dx_s1 * dx_s1);
			qy_s2 <= sfc_pkg::DIST2_W'(dy_s1 * dy_s1);
			qz_s2 <= sfc_pkg::DIST2_W'(dz_s1 * dz_s1);
			sum_s3 <= qx_s2 + qy_s2 + qz_s2;
		end
	end

	sfc_pkg::root_t rt [sfc_pkg::ROOT_STAGES+1];
	assign rt[0] = '{rem: sum_s3, root: '0};

	generate
		for (g = 0; g < sfc_pkg::ROOT_STAGES; g++) begin : g_root
			sfc_root_cell #(.STEP(g)) u_root (
				.clk(clk), .en(adv), .in_q(rt[g]), .out_q(rt[g+1])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (adv) begin
			v_q <= {v_q[CHAIN_LAT-1:0], in_valid};
		end
	end

	logic [sfc_pkg::ROOT_W-1:0] dist_root;
	logic [sfc_pkg::LOD_W-1:0] lvl;
	assign dist_root = rt[sfc_pkg::ROOT_STAGES].root;

	always_comb begin
		lvl = sfc_pkg::LOD_FAR;
		for (int k = 3; k >= 0; k--) begin
			if ({10'd0, dist_root} < ({20'd0, thr[16*k +: 16]} << COORD_FRAC_BITS))
				lvl = sfc_pkg::LOD_W'(k);
		end
	end

	logic ov_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ov_q <= 1'b0;
		else if (adv) ov_q <= v_q[CHAIN_LAT];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			visible <= vis_c[sfc_pkg::NUM_PLANES];
			lod_level <= lvl;
			camera_distance <= (dist_root > sfc_pkg::ROOT_W'(24'hFFFFFF)) ? 24'hFFFFFF
				: dist_root[sfc_pkg::DIST_W-1:0];
		end
	end

	assign out_valid = ov_q;

endmodule
